// File: hdl/pclb_pkg.sv
// Shared types, codes and fixed widths of the particle cell-list binning block.
`default_nettype none

package pclb_pkg;

   // result status codes
   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   // register indexes
   localparam int         CSR_IDX_W     = 3;
   localparam logic [2:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [2:0] CSR_RECIP_A_X = 3'd2;
   localparam logic [2:0] CSR_RECIP_A_Y = 3'd3;
   localparam logic [2:0] CSR_RECIP_B_X = 3'd4;
   localparam logic [2:0] CSR_RECIP_B_Y = 3'd5;
   localparam logic [2:0] CSR_CELLS_A   = 3'd6;
   localparam logic [2:0] CSR_CELLS_B   = 3'd7;

   // size threshold, 10.0 in Q16.16
   localparam logic [31:0] SIZE_LIMIT = 32'd655360;

   // frame epoch carried with every word and stored with every count
   localparam int                 EPOCH_W    = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

   // datapath widths
   localparam int DIFF_W  = 33;  // pos - origin
   localparam int PROD_W  = 65;  // Q32.32 product
   localparam int SUM_W   = 66;  // sum of two products
   localparam int SCALE_W = 74;  // sum times subcell count
   localparam int IC_W    = 42;  // floored subcell coordinate
   localparam int LIN_W   = 51;  // ic*cells_b + jc
   localparam int LIM_W   = 17;  // cell limit, up to 65536
   localparam int IDX_W   = 16;  // cell index carried in a queue word

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] recip_a_x;
      logic signed [31:0] recip_a_y;
      logic signed [31:0] recip_b_x;
      logic signed [31:0] recip_b_y;
      logic [6:0]         cells_a;
      logic [6:0]         cells_b;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        pid;
      logic [EPOCH_W-1:0] epoch;
      logic [1:0]         status;
      logic [IDX_W-1:0]   cell_idx;
   } item_type;

   typedef struct packed {
      logic scrub_start;
   } front_ctl_type;

   typedef struct packed {
      logic scrub_busy;
      logic drained;
   } back_status_type;

endpackage

`default_nettype wire

// File: hdl/pclb_req_if.sv
// Particle request channel: valid/ready plus one particle word.
`default_nettype none

interface pclb_req_if;
   logic               valid;
   logic               ready;
   logic               new_frame;
   logic [15:0]        particle_id;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0]        particle_size;

   modport source (output valid, new_frame, particle_id, pos_x, pos_y, particle_size,
                   input ready);
   modport sink   (input valid, new_frame, particle_id, pos_x, pos_y, particle_size,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/pclb_rsp_if.sv
// Binning result channel: valid/ready plus one result word.
`default_nettype none

interface pclb_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] cell_index;
   logic [3:0]  slot;
   logic [1:0]  status;

   modport source (output valid, cell_index, slot, status, input ready);
   modport sink   (input valid, cell_index, slot, status, output ready);
endinterface

`default_nettype wire

// File: hdl/pclb_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module pclb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we_i,
   input  logic [AW-1:0]    waddr_i,
   input  logic [WIDTH-1:0] wdata_i,
   input  logic             re_i,
   input  logic [AW-1:0]    raddr_i,
   output logic [WIDTH-1:0] rdata_o
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read during write returns the old entry
   always_ff @(posedge clock) begin
      if (we_i) begin
         mem_ff[waddr_i] <= wdata_i;
      end
      if (re_i) begin
         rdata_ff <= mem_ff[raddr_i];
      end
   end

   assign rdata_o = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/pclb_front.sv
// Front end: accepts particles, computes the subcell index and classifies each word.
`default_nettype none

module pclb_front #(
   parameter int MAX_CELLS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pclb_pkg::cfg_type         cfg_i,
   pclb_req_if.sink                  req,
   output logic                      q_valid_o,
   input  logic                      q_ready_i,
   output pclb_pkg::item_type        q_item_o,
   input  pclb_pkg::back_status_type bk_i,
   output pclb_pkg::front_ctl_type   ctl_o
);

   typedef struct packed {
      logic [15:0]                  pid;
      logic [pclb_pkg::EPOCH_W-1:0] epoch;
      logic                         big;
   } tag_type;

   localparam int DIFF_W  = pclb_pkg::DIFF_W;
   localparam int PROD_W  = pclb_pkg::PROD_W;
   localparam int SUM_W   = pclb_pkg::SUM_W;
   localparam int SCALE_W = pclb_pkg::SCALE_W;
   localparam int IC_W    = pclb_pkg::IC_W;
   localparam int LIN_W   = pclb_pkg::LIN_W;
   localparam int LIM_W   = pclb_pkg::LIM_W;
   localparam int IDX_W   = pclb_pkg::IDX_W;
   localparam int EPOCH_W = pclb_pkg::EPOCH_W;

   // epoch and wrap scrub control
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               scrub_wait_ff, scrub_wait_in;
   logic               scrub_done_ff, scrub_done_in;
   logic               wrap_hold, scrub_start, front_empty, adv, accept;

   // pipeline
   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   tag_type                  tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag1_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [PROD_W-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;
   logic signed [PROD_W-1:0] pax_in, pay_in, pbx_in, pby_in;
   logic signed [SUM_W-1:0]  sa_ff, sb_ff, sa_in, sb_in;
   logic signed [SCALE_W-1:0] scale_a, scale_b;
   logic signed [IC_W-1:0]   ic_ff, jc_ff, ic_in, jc_in;
   logic signed [LIN_W-1:0]  lin_ff, lin_in;

   logic [13:0]       limit_prod;
   logic [LIM_W-1:0]  limit;
   logic              out_range;
   logic [1:0]        status;

   assign adv         = !v5_ff || q_ready_i;
   assign front_empty = !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff);
   assign wrap_hold   = req.new_frame && (epoch_ff == pclb_pkg::EPOCH_LAST) && !scrub_done_ff;
   assign req.ready   = adv && !bk_i.scrub_busy && !wrap_hold && !scrub_wait_ff;
   assign accept      = req.valid && req.ready;

   // a wrapping epoch needs every stored count cleared first, with nothing in flight
   assign scrub_start = req.valid && wrap_hold && !scrub_wait_ff && front_empty
                        && bk_i.drained && !bk_i.scrub_busy;
   assign ctl_o.scrub_start = scrub_start;

   always_comb begin
      epoch_in      = (accept && req.new_frame) ? epoch_ff + 1'b1 : epoch_ff;
      scrub_wait_in = scrub_wait_ff;
      if (scrub_start) begin
         scrub_wait_in = 1'b1;
      end else if (scrub_wait_ff && !bk_i.scrub_busy) begin
         scrub_wait_in = 1'b0;
      end
      scrub_done_in = scrub_done_ff;
      if (scrub_wait_ff && !bk_i.scrub_busy) begin
         scrub_done_in = 1'b1;
      end else if (accept && req.new_frame) begin
         scrub_done_in = 1'b0;
      end
   end

   always_comb begin
      tag1_in.pid   = req.particle_id;
      tag1_in.epoch = epoch_in;
      tag1_in.big   = req.particle_size > pclb_pkg::SIZE_LIMIT;
      dx_in  = {req.pos_x[31], req.pos_x} - {cfg_i.origin_x[31], cfg_i.origin_x};
      dy_in  = {req.pos_y[31], req.pos_y} - {cfg_i.origin_y[31], cfg_i.origin_y};
      pax_in = dx_ff * cfg_i.recip_a_x;
      pay_in = dy_ff * cfg_i.recip_a_y;
      pbx_in = dx_ff * cfg_i.recip_b_x;
      pby_in = dy_ff * cfg_i.recip_b_y;
      sa_in  = pax_ff + pay_ff;
      sb_in  = pbx_ff + pby_ff;
      // floor by taking the high bits of the exact product
      scale_a = sa_ff * $signed({1'b0, cfg_i.cells_a});
      scale_b = sb_ff * $signed({1'b0, cfg_i.cells_b});
      ic_in   = scale_a[SCALE_W-1:32];
      jc_in   = scale_b[SCALE_W-1:32];
      lin_in  = ic_ff * $signed({1'b0, cfg_i.cells_b}) + jc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= '0;
         scrub_wait_ff <= 1'b0;
         scrub_done_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         epoch_ff      <= epoch_in;
         scrub_wait_ff <= scrub_wait_in;
         scrub_done_ff <= scrub_done_in;
         if (adv) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff <= tag1_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         tag2_ff <= tag1_ff;
         pax_ff  <= pax_in;
         pay_ff  <= pay_in;
         pbx_ff  <= pbx_in;
         pby_ff  <= pby_in;
         tag3_ff <= tag2_ff;
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         tag4_ff <= tag3_ff;
         ic_ff   <= ic_in;
         jc_ff   <= jc_in;
         tag5_ff <= tag4_ff;
         lin_ff  <= lin_in;
      end
   end

   // classification at the queue push
   always_comb begin
      limit_prod = {7'd0, cfg_i.cells_a} * {7'd0, cfg_i.cells_b};
      limit      = (LIM_W'(limit_prod) > LIM_W'(MAX_CELLS)) ? LIM_W'(MAX_CELLS)
                                                            : LIM_W'(limit_prod);
      out_range  = lin_ff[LIN_W-1] || (lin_ff >= LIN_W'(limit));
      if (tag5_ff.big) begin
         status = pclb_pkg::STATUS_SKIPPED;
      end else if (out_range) begin
         status = pclb_pkg::STATUS_RANGE;
      end else begin
         status = pclb_pkg::STATUS_STORED;
      end
      q_item_o.pid      = tag5_ff.pid;
      q_item_o.epoch    = tag5_ff.epoch;
      q_item_o.status   = status;
      q_item_o.cell_idx = (status == pclb_pkg::STATUS_STORED) ? IDX_W'(lin_ff) : '0;
   end

   assign q_valid_o = v5_ff;

   a_wrap_after_scrub: assert property (@(posedge clock) disable iff (reset)
      (accept && req.new_frame && epoch_ff == pclb_pkg::EPOCH_LAST) |-> scrub_done_ff)
      else $error("epoch wrapped without a count scrub");

   a_scrub_from_empty: assert property (@(posedge clock) disable iff (reset)
      scrub_start |=> (scrub_wait_ff && !v1_ff && !req.ready))
      else $error("words entered the pipeline around a scrub start");

endmodule

`default_nettype wire

// File: hdl/pclb_queue.sv
// Short word queue between the front end and the back end.
`default_nettype none

module pclb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid_i,
   output logic               push_ready_o,
   input  pclb_pkg::item_type push_item_i,
   output logic               pop_valid_o,
   input  logic               pop_ready_i,
   output pclb_pkg::item_type pop_item_o
);

   localparam int QPTR_W = pclb_pkg::QPTR_W;
   localparam int QCNT_W = pclb_pkg::QCNT_W;
   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(pclb_pkg::QUEUE_DEPTH - 1);

   pclb_pkg::item_type slot_ff [pclb_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign push_ready_o = count_ff != QCNT_W'(pclb_pkg::QUEUE_DEPTH);
   assign pop_valid_o  = count_ff != '0;
   assign push         = push_valid_i && push_ready_o;
   assign pop          = pop_valid_o && pop_ready_i;
   assign pop_item_o   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item_i;
      end
   end

endmodule

`default_nettype wire

// File: hdl/pclb_back.sv
// Back end: per-cell count update, member list write, count scrub and result register.
`default_nettype none

module pclb_back #(
   parameter int MAX_CELLS     = 4096,
   parameter int CELL_CAPACITY = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid_i,
   output logic                      in_ready_o,
   input  pclb_pkg::item_type        in_item_i,
   input  pclb_pkg::front_ctl_type   ctl_i,
   output pclb_pkg::back_status_type sts_o,
   pclb_rsp_if.source                rsp
);

   localparam int EPOCH_W   = pclb_pkg::EPOCH_W;
   localparam int CELL_AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CNT_W     = $clog2(CELL_CAPACITY + 1);
   localparam int ENTRY_W   = EPOCH_W + CNT_W;
   localparam int MEM_DEPTH = MAX_CELLS * CELL_CAPACITY;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam logic [CELL_AW-1:0] SCRUB_LAST = CELL_AW'(MAX_CELLS - 1);
   localparam logic [CNT_W-1:0]   CAP        = CNT_W'(CELL_CAPACITY);

   // bin stage
   logic               b1_valid_ff, b1_valid_in;
   pclb_pkg::item_type b1_item_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0] fwd_entry_ff;
   logic [ENTRY_W-1:0] cnt_rdata, entry, upd_entry;
   logic [CNT_W-1:0]   cnt_eff;
   logic               room, do_store, fire, load, upd_we;
   logic [CELL_AW-1:0] b1_cell, in_cell;

   // scrub
   logic               scrub_busy_ff, scrub_busy_in;
   logic [CELL_AW-1:0] scrub_addr_ff, scrub_addr_in;

   // count RAM write port
   logic               cnt_we;
   logic [CELL_AW-1:0] cnt_waddr;
   logic [ENTRY_W-1:0] cnt_wdata;

   // member write, registered from the count update and done in the cycle after it
   logic               mw_valid_ff;
   logic [CELL_AW-1:0] mw_cell_ff;
   logic [CNT_W-1:0]   mw_slot_ff;
   logic [15:0]        mw_pid_ff;
   logic [MEM_AW-1:0]  mw_addr;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [11:0] out_cell_ff, out_cell_in;
   logic [3:0]  out_slot_ff, out_slot_in;
   logic [1:0]  out_status_ff, out_status_in;

   assign b1_cell = b1_item_ff.cell_idx[CELL_AW-1:0];
   assign in_cell = in_item_i.cell_idx[CELL_AW-1:0];

   assign fire       = b1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready_o = !scrub_busy_ff && (!b1_valid_ff || fire);
   assign load       = in_valid_i && in_ready_o;

   // the RAM returns the old entry when the previous word wrote it in the read cycle
   always_comb begin
      entry     = fwd_hit_ff ? fwd_entry_ff : cnt_rdata;
      cnt_eff   = (entry[ENTRY_W-1:CNT_W] == b1_item_ff.epoch) ? entry[CNT_W-1:0] : '0;
      room      = cnt_eff < CAP;
      do_store  = (b1_item_ff.status == pclb_pkg::STATUS_STORED) && room;
      upd_we    = fire && do_store;
      upd_entry = {b1_item_ff.epoch, CNT_W'(cnt_eff + 1'b1)};
      fwd_hit_in = upd_we && (b1_cell == in_cell);
      b1_valid_in = load ? 1'b1 : (fire ? 1'b0 : b1_valid_ff);
   end

   always_comb begin
      scrub_busy_in = scrub_busy_ff;
      scrub_addr_in = scrub_addr_ff;
      if (ctl_i.scrub_start) begin
         scrub_busy_in = 1'b1;
         scrub_addr_in = '0;
      end else if (scrub_busy_ff) begin
         scrub_addr_in = scrub_addr_ff + 1'b1;
         if (scrub_addr_ff == SCRUB_LAST) begin
            scrub_busy_in = 1'b0;
         end
      end
      cnt_we    = upd_we || scrub_busy_ff;
      cnt_waddr = scrub_busy_ff ? scrub_addr_ff : b1_cell;
      cnt_wdata = scrub_busy_ff ? '0 : upd_entry;
   end

   always_comb begin
      out_valid_in  = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
      out_cell_in   = do_store ? 12'(b1_item_ff.cell_idx) : '0;
      out_slot_in   = do_store ? 4'(cnt_eff) : '0;
      out_status_in = ((b1_item_ff.status == pclb_pkg::STATUS_STORED) && !room)
                      ? pclb_pkg::STATUS_FULL : b1_item_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff   <= 1'b0;
         scrub_busy_ff <= 1'b1;
         scrub_addr_ff <= '0;
         mw_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         b1_valid_ff   <= b1_valid_in;
         scrub_busy_ff <= scrub_busy_in;
         scrub_addr_ff <= scrub_addr_in;
         mw_valid_ff   <= upd_we;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         b1_item_ff   <= in_item_i;
         fwd_hit_ff   <= fwd_hit_in;
         fwd_entry_ff <= upd_entry;
      end
      if (upd_we) begin
         mw_cell_ff <= b1_cell;
         mw_slot_ff <= cnt_eff;
         mw_pid_ff  <= b1_item_ff.pid;
      end
      if (fire) begin
         out_cell_ff   <= out_cell_in;
         out_slot_ff   <= out_slot_in;
         out_status_ff <= out_status_in;
      end
   end

   assign mw_addr = MEM_AW'(mw_cell_ff) * MEM_AW'(CELL_CAPACITY) + MEM_AW'(mw_slot_ff);

   pclb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CELLS)
   ) u_count_ram (
      .clock   (clock),
      .we_i    (cnt_we),
      .waddr_i (cnt_waddr),
      .wdata_i (cnt_wdata),
      .re_i    (load),
      .raddr_i (in_cell),
      .rdata_o (cnt_rdata)
   );

   pclb_ram #(
      .WIDTH (16),
      .DEPTH (MEM_DEPTH)
   ) u_member_ram (
      .clock   (clock),
      .we_i    (mw_valid_ff),
      .waddr_i (mw_addr),
      .wdata_i (mw_pid_ff),
      .re_i    (1'b0),
      .raddr_i (mw_addr),
      .rdata_o ()
   );

   assign sts_o.scrub_busy = scrub_busy_ff;
   assign sts_o.drained    = !b1_valid_ff && !in_valid_i;

   assign rsp.valid      = out_valid_ff;
   assign rsp.cell_index = out_cell_ff;
   assign rsp.slot       = out_slot_ff;
   assign rsp.status     = out_status_ff;

   a_scrub_alone: assert property (@(posedge clock) disable iff (reset)
      scrub_busy_ff |-> (!b1_valid_ff && !in_ready_o))
      else $error("word in the bin stage during a count scrub");

   a_scrub_runs: assert property (@(posedge clock) disable iff (reset)
      ctl_i.scrub_start |=> scrub_busy_ff)
      else $error("scrub request not taken");

   a_unstored_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != pclb_pkg::STATUS_STORED)
      |-> (out_cell_ff == '0 && out_slot_ff == '0))
      else $error("index or slot set on a word that was not stored");

endmodule

`default_nettype wire

// File: hdl/particle_cell_list_binning_top.sv
// Top level of the particle cell-list binning block: registers, front, queue and back.
//
// Usage:
//   req_bus carries one particle word per handshake (new_frame, id, position, size);
//   rsp_bus returns exactly one result word per particle, in order: cell index,
//   slot and status (stored, skipped large, cell out of range, cell full).
//   csr_we/csr_index/csr_wdata write the origin, reciprocal basis and subcell counts;
//   write them only while no particle is in flight.
// Timing:
//   A word goes through five front stages, queue, bin stage and result register.
//   Sustained rate is one particle per clock, with no stall or scrub: the five-stage
//   front pipeline and the count read-modify-write in the back end both take a word
//   each cycle; a same-cell update in consecutive words uses a bypass register.
// Reset:
//   Counts live in a RAM tagged with an 8-bit frame epoch. After reset the back
//   end clears that RAM, one cell after another, while req_bus.ready stays low. The same
//   clearing pass runs on every 256th new_frame word, once the pipeline drains.
// Stalls:
//   A low rsp_bus.ready holds the result register; the back end, the queue and the
//   front pipeline then fill up and req_bus.ready drops, no word is lost.
`default_nettype none

module particle_cell_list_binning_top #(
   parameter int MAX_CELLS     = 4096,
   parameter int CELL_CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   pclb_req_if.sink    req_bus,
   pclb_rsp_if.source  rsp_bus,
   input  logic                           csr_we,
   input  logic [pclb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   pclb_pkg::cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pclb_pkg::CSR_ORIGIN_X:  cfg_in.origin_x  = csr_wdata;
            pclb_pkg::CSR_ORIGIN_Y:  cfg_in.origin_y  = csr_wdata;
            pclb_pkg::CSR_RECIP_A_X: cfg_in.recip_a_x = csr_wdata;
            pclb_pkg::CSR_RECIP_A_Y: cfg_in.recip_a_y = csr_wdata;
            pclb_pkg::CSR_RECIP_B_X: cfg_in.recip_b_x = csr_wdata;
            pclb_pkg::CSR_RECIP_B_Y: cfg_in.recip_b_y = csr_wdata;
            pclb_pkg::CSR_CELLS_A:   cfg_in.cells_a   = csr_wdata[6:0];
            pclb_pkg::CSR_CELLS_B:   cfg_in.cells_b   = csr_wdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x  <= '0;
         cfg_ff.origin_y  <= '0;
         cfg_ff.recip_a_x <= '0;
         cfg_ff.recip_a_y <= '0;
         cfg_ff.recip_b_x <= '0;
         cfg_ff.recip_b_y <= '0;
         cfg_ff.cells_a   <= 7'd1;
         cfg_ff.cells_b   <= 7'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front to queue
   logic               push_valid, push_ready;
   pclb_pkg::item_type push_item;
   // queue to back
   logic               pop_valid, pop_ready;
   pclb_pkg::item_type pop_item;
   // scrub handshake between front and back
   pclb_pkg::front_ctl_type   front_ctl;
   pclb_pkg::back_status_type back_sts;

   pclb_front #(
      .MAX_CELLS (MAX_CELLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg_i     (cfg_ff),
      .req       (req_bus),
      .q_valid_o (push_valid),
      .q_ready_i (push_ready),
      .q_item_o  (push_item),
      .bk_i      (back_sts),
      .ctl_o     (front_ctl)
   );

   pclb_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid_i (push_valid),
      .push_ready_o (push_ready),
      .push_item_i  (push_item),
      .pop_valid_o  (pop_valid),
      .pop_ready_i  (pop_ready),
      .pop_item_o   (pop_item)
   );

   pclb_back #(
      .MAX_CELLS     (MAX_CELLS),
      .CELL_CAPACITY (CELL_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid_i (pop_valid),
      .in_ready_o (pop_ready),
      .in_item_i  (pop_item),
      .ctl_i      (front_ctl),
      .sts_o      (back_sts),
      .rsp        (rsp_bus)
   );

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the particle cell-list binning block.
`default_nettype none

module tb;

   localparam int MAX_CELLS     = 4096;
   localparam int CELL_CAPACITY = 16;
   localparam int RANDOM_ITEMS  = 1550;
   localparam int DRAIN_PAUSE   = 24;       // result latency plus margin
   localparam int CYCLE_LIMIT   = 1000000;

   // one particle word as it goes on the request channel
   typedef struct packed {
      logic               new_frame;
      logic [15:0]        particle_id;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        particle_size;
   } particle_type;

   // one binning result word
   typedef struct packed {
      logic [11:0] cell_index;
      logic [3:0]  slot;
      logic [1:0]  status;
   } bin_result_type;

   // ---------------------------------------------------------------------------------
   // clock, reset and every DUT input start at known values
   // ---------------------------------------------------------------------------------
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         csr_we    = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   logic         drv_valid = 1'b0;
   particle_type drv_item  = '0;
   logic         rsp_rdy   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   pclb_req_if req_bus ();
   pclb_rsp_if rsp_bus ();

   assign req_bus.valid         = drv_valid;
   assign req_bus.new_frame     = drv_item.new_frame;
   assign req_bus.particle_id   = drv_item.particle_id;
   assign req_bus.pos_x         = drv_item.pos_x;
   assign req_bus.pos_y         = drv_item.pos_y;
   assign req_bus.particle_size = drv_item.particle_size;
   assign rsp_bus.ready         = rsp_rdy;

   particle_cell_list_binning_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // predictor: own copy of the registers and the per-cell counts
   // ---------------------------------------------------------------------------------
   pclb_pkg::cfg_type bin_cfg;
   int                bin_count [MAX_CELLS] = '{default: 0};

   particle_type   particles_to_send [$];
   bin_result_type bin_results_due [$];
   int             particles_queued = 0;
   int             results_seen     = 0;
   int             errors           = 0;
   int             cycle_count      = 0;
   logic           req_fire         = 1'b0;

   // floor(n * (d . r) / 2^32), exact: 128 bits hold every intermediate
   function automatic logic signed [127:0] axis_floor(particle_type p,
                                                      logic signed [31:0] rx,
                                                      logic signed [31:0] ry,
                                                      logic [6:0] n);
      logic signed [127:0] dx, dy, acc;
      dx  = 128'($signed(p.pos_x)) - 128'($signed(bin_cfg.origin_x));
      dy  = 128'($signed(p.pos_y)) - 128'($signed(bin_cfg.origin_y));
      acc = dx * 128'($signed(rx)) + dy * 128'($signed(ry));
      acc = acc * 128'($signed({1'b0, n}));
      return acc >>> 32;
   endfunction

   // expected result of one accepted particle word; updates the counts
   function automatic bin_result_type bin_particle(particle_type p);
      bin_result_type      r;
      logic signed [127:0] ic, jc, lin;
      int                  lim, cnt;
      r = '0;
      // new frame empties every cell, even when this particle is skipped
      if (p.new_frame) begin
         foreach (bin_count[i]) bin_count[i] = 0;
      end
      if (p.particle_size > pclb_pkg::SIZE_LIMIT) begin
         r.status = pclb_pkg::STATUS_SKIPPED;
         return r;
      end
      ic  = axis_floor(p, bin_cfg.recip_a_x, bin_cfg.recip_a_y, bin_cfg.cells_a);
      jc  = axis_floor(p, bin_cfg.recip_b_x, bin_cfg.recip_b_y, bin_cfg.cells_b);
      lin = ic * 128'($signed({1'b0, bin_cfg.cells_b})) + jc;
      lim = int'(bin_cfg.cells_a) * int'(bin_cfg.cells_b);
      if (lim > MAX_CELLS) lim = MAX_CELLS;
      // only the linear index is range checked, a negative ic or jc may pass
      if (lin < 0 || lin >= 128'(lim)) begin
         r.status = pclb_pkg::STATUS_RANGE;
         return r;
      end
      cnt = bin_count[lin[11:0]];
      if (cnt >= CELL_CAPACITY) begin
         r.status = pclb_pkg::STATUS_FULL;
         return r;
      end
      bin_count[lin[11:0]] = cnt + 1;
      r.cell_index = lin[11:0];
      r.slot       = 4'(cnt);
      r.status     = pclb_pkg::STATUS_STORED;
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         4: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // request driver: changes at the falling edge, holds a word until taken
   // ---------------------------------------------------------------------------------
   int gap_left = 0;
   int drv_calm = 0;

   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_fire) begin
         if (gap_left > 0) begin
            drv_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (particles_to_send.size() > 0) begin
            drv_item  <= particles_to_send.pop_front();
            drv_valid <= 1'b1;
            // a calm stretch sends back to back
            if (drv_calm > 0) begin
               drv_calm <= drv_calm - 1;
               gap_left <= 0;
            end else begin
               gap_left <= pick_gap();
               if ($urandom_range(0, 49) == 0) drv_calm <= $urandom_range(20, 60);
            end
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // result side backpressure: random stalls, with calm stretches
   // ---------------------------------------------------------------------------------
   int stall_left = 0;
   int rsp_calm   = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_rdy <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_rdy    <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_rdy <= 1'b1;
         if (rsp_calm > 0) rsp_calm <= rsp_calm - 1;
         else if ($urandom_range(0, 99) < 4) rsp_calm <= $urandom_range(30, 80);
         else if ($urandom_range(0, 99) < 20) stall_left <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------------------
   // monitor: at the rising edge, predict each taken particle word and check each
   // result word against the oldest expectation
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      bin_result_type got, want;
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, bin_results_due.size());
         $display("tb: FAIL");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) bin_results_due.push_back(bin_particle(drv_item));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.cell_index = rsp_bus.cell_index;
            got.slot       = rsp_bus.slot;
            got.status     = rsp_bus.status;
            results_seen   = results_seen + 1;
            if (bin_results_due.size() == 0) begin
               $display("%0t: unexpected result, index %0d slot %0d status %0d",
                        $time, got.cell_index, got.slot, got.status);
               errors = errors + 1;
            end else begin
               want = bin_results_due.pop_front();
               if (got.cell_index !== want.cell_index || got.slot !== want.slot ||
                   got.status !== want.status) begin
                  $display({"%0t: mismatch, expected index %0d slot %0d status %0d,",
                            " got index %0d slot %0d status %0d"},
                           $time, want.cell_index, want.slot, want.status,
                           got.cell_index, got.slot, got.status);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------
   task automatic queue_particle(input logic nf, input logic [15:0] pid,
                                 input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] size);
      particle_type p;
      p.new_frame     = nf;
      p.particle_id   = pid;
      p.pos_x         = x;
      p.pos_y         = y;
      p.particle_size = size;
      particles_to_send.push_back(p);
      particles_queued = particles_queued + 1;
   endtask

   // every word answered, then the pipeline latency on top
   task automatic wait_drained();
      while (results_seen < particles_queued) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   // register write at the falling edge; the predictor copy follows at once
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         pclb_pkg::CSR_ORIGIN_X:  bin_cfg.origin_x  = data;
         pclb_pkg::CSR_ORIGIN_Y:  bin_cfg.origin_y  = data;
         pclb_pkg::CSR_RECIP_A_X: bin_cfg.recip_a_x = data;
         pclb_pkg::CSR_RECIP_A_Y: bin_cfg.recip_a_y = data;
         pclb_pkg::CSR_RECIP_B_X: bin_cfg.recip_b_x = data;
         pclb_pkg::CSR_RECIP_B_Y: bin_cfg.recip_b_y = data;
         pclb_pkg::CSR_CELLS_A:   bin_cfg.cells_a   = data[6:0];
         default:                 bin_cfg.cells_b   = data[6:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_config(input pclb_pkg::cfg_type c);
      write_reg(pclb_pkg::CSR_ORIGIN_X,  c.origin_x);
      write_reg(pclb_pkg::CSR_ORIGIN_Y,  c.origin_y);
      write_reg(pclb_pkg::CSR_RECIP_A_X, c.recip_a_x);
      write_reg(pclb_pkg::CSR_RECIP_A_Y, c.recip_a_y);
      write_reg(pclb_pkg::CSR_RECIP_B_X, c.recip_b_x);
      write_reg(pclb_pkg::CSR_RECIP_B_Y, c.recip_b_y);
      write_reg(pclb_pkg::CSR_CELLS_A,   {25'd0, c.cells_a});
      write_reg(pclb_pkg::CSR_CELLS_B,   {25'd0, c.cells_b});
   endtask

   // ---------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      pclb_pkg::cfg_type c;
      logic              nf, storm;
      logic [31:0]       x, y, size;
      int                kind, n_items, frame_left, span_a, span_b, ra, rb, phase, total, r;

      // reset values of the registers
      bin_cfg         = '0;
      bin_cfg.cells_a = 7'd1;
      bin_cfg.cells_b = 7'd1;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed, reset registers: zero basis puts every particle in cell 0 of a 1x1 grid
      queue_particle(1'b0, 16'h0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
      queue_particle(1'b0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, pclb_pkg::SIZE_LIMIT);
      queue_particle(1'b0, 16'h1234, 32'h8000_0000, 32'h7FFF_FFFF,
                     pclb_pkg::SIZE_LIMIT + 32'd1);
      queue_particle(1'b0, 16'h4321, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      for (int i = 2; i < CELL_CAPACITY; i++)
         queue_particle(1'b0, 16'(i), $urandom, $urandom,
                        $urandom_range(0, pclb_pkg::SIZE_LIMIT));
      // cell 0 is full now
      queue_particle(1'b0, 16'hABCD, 32'h0000_0000, 32'h0000_0000, 32'd0);
      // a skipped particle still opens a new frame
      queue_particle(1'b1, 16'h5555, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_particle(1'b0, 16'hAAAA, 32'h0000_0000, 32'h0000_0000, 32'd0);
      queue_particle(1'b1, 16'h0F0F, 32'h0000_0000, 32'h0000_0000, 32'd0);
      wait_drained();

      // directed, register extremes on the largest grid
      c.origin_x  = 32'h8000_0000;
      c.origin_y  = 32'h7FFF_FFFF;
      c.recip_a_x = 32'h7FFF_FFFF;
      c.recip_a_y = 32'h8000_0000;
      c.recip_b_x = 32'h8000_0000;
      c.recip_b_y = 32'h7FFF_FFFF;
      c.cells_a   = 7'd64;
      c.cells_b   = 7'd64;
      apply_config(c);
      queue_particle(1'b0, 16'h0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      queue_particle(1'b0, 16'h0002, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
      // particle right on the origin lands in cell 0
      queue_particle(1'b0, 16'h0003, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);

      // random phases, each with its own register setting
      phase = 0;
      total = 0;
      while (total < RANDOM_ITEMS) begin
         wait_drained();
         // one phase of back to back new frames walks the frame epoch past its wrap
         storm = (phase == 2);
         r     = $urandom_range(0, 99);
         kind  = (storm || r < 65) ? 0 : (r < 82) ? 1 : 2;
         span_a = $urandom_range(2 << 16, 200 << 16);
         span_b = $urandom_range(2 << 16, 200 << 16);
         case (kind)
            0: begin
               // skewed cell of sane geometry, reciprocal basis about 1/side
               ra = int'((64'd1 << 32) / 64'(span_a));
               rb = int'((64'd1 << 32) / 64'(span_b));
               c.origin_x  = int'($urandom_range(0, 1 << 30)) - (1 << 29);
               c.origin_y  = int'($urandom_range(0, 1 << 30)) - (1 << 29);
               c.recip_a_x = ra;
               c.recip_a_y = int'($urandom_range(0, ra / 4)) - ra / 8;
               c.recip_b_x = int'($urandom_range(0, rb / 4)) - rb / 8;
               c.recip_b_y = rb;
               // small grids fill cells up
               if ($urandom_range(0, 9) < 7) begin
                  c.cells_a = 7'($urandom_range(1, 4));
                  c.cells_b = 7'($urandom_range(1, 4));
               end else begin
                  c.cells_a = ($urandom_range(0, 9) == 0) ? 7'd64 : 7'($urandom_range(1, 64));
                  c.cells_b = ($urandom_range(0, 9) == 0) ? 7'd64 : 7'($urandom_range(1, 64));
               end
            end
            1: begin
               c.origin_x  = $urandom;
               c.origin_y  = $urandom;
               c.recip_a_x = $urandom;
               c.recip_a_y = $urandom;
               c.recip_b_x = $urandom;
               c.recip_b_y = $urandom;
               c.cells_a   = 7'($urandom_range(1, 64));
               c.cells_b   = 7'($urandom_range(1, 64));
            end
            default: begin
               c.origin_x  = pick_extreme();
               c.origin_y  = pick_extreme();
               c.recip_a_x = pick_extreme();
               c.recip_a_y = pick_extreme();
               c.recip_b_x = pick_extreme();
               c.recip_b_y = pick_extreme();
               c.cells_a   = $urandom_range(0, 1) ? 7'd64 : 7'd1;
               c.cells_b   = $urandom_range(0, 1) ? 7'd64 : 7'd1;
            end
         endcase
         apply_config(c);

         n_items    = storm ? 300 : $urandom_range(40, 150);
         frame_left = 0;
         repeat (n_items) begin
            // frames: a new_frame word, then a run of plain words, a stray flag now and then
            if (frame_left == 0) begin
               nf         = ($urandom_range(0, 9) != 0);
               frame_left = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            end else begin
               nf = ($urandom_range(0, 33) == 0);
            end
            frame_left = frame_left - 1;
            if (storm) nf = 1'b1;

            case (kind)
               0: begin
                  if ($urandom_range(0, 9) < 8) begin
                     x = c.origin_x + int'($urandom_range(0, span_a + span_a / 5)) - span_a / 10;
                     y = c.origin_y + int'($urandom_range(0, span_b + span_b / 5)) - span_b / 10;
                  end else begin
                     x = $urandom;
                     y = $urandom;
                  end
               end
               1: begin
                  if ($urandom_range(0, 1)) begin
                     x = $urandom;
                     y = $urandom;
                  end else begin
                     x = c.origin_x + int'($urandom_range(0, 1 << 21)) - (1 << 20);
                     y = c.origin_y + int'($urandom_range(0, 1 << 21)) - (1 << 20);
                  end
               end
               default: begin
                  x = pick_extreme();
                  y = pick_extreme();
               end
            endcase

            r = $urandom_range(0, 99);
            if (r < 80)      size = $urandom_range(0, pclb_pkg::SIZE_LIMIT);
            else if (r < 90) size = pclb_pkg::SIZE_LIMIT + 32'($urandom_range(0, 1));
            else             size = $urandom;

            queue_particle(nf, 16'($urandom), x, y, size);
         end
         total = total + n_items;
         phase = phase + 1;
      end

      wait_drained();
      if (errors == 0 && bin_results_due.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
hdl/pclb_pkg.sv
hdl/pclb_req_if.sv
hdl/pclb_rsp_if.sv
hdl/pclb_ram.sv
hdl/pclb_front.sv
hdl/pclb_queue.sv
hdl/pclb_back.sv
hdl/particle_cell_list_binning_top.sv
test/tb.sv
